/* design/uem_pkg.sv */
`default_nettype none

package uem_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int FACTOR_W   = 6;
    localparam int PHASE_W    = 6;
    localparam int FUNC_W     = 2;
    localparam int CLIP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MIX     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_8BIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd2;

    // Clip flags
    localparam logic [CLIP_W-1:0] CLIP_NONE = 2'd0;
    localparam logic [CLIP_W-1:0] CLIP_HIGH = 2'd1;
    localparam logic [CLIP_W-1:0] CLIP_LOW  = 2'd2;

    // Interpolation numerator, divider and gain
    localparam int NUM_W      = 25;
    localparam int DIV_W      = 24;
    localparam int DIV_RADIX  = 4;
    localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int INTERP_W   = 17;
    localparam int PROD_W     = 32;
    localparam int GAIN_SHIFT = 16;
    localparam logic signed [15:0] GAIN = 16'sd19661;

    typedef struct packed {
        logic take;
        logic num_en;
        logic div_step;
        logic scale_en;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] rem;
        logic [DIV_W-1:0]    quo;
    } div_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CLIP_W-1:0]          clip;
    } sat_t;

    // Expand a raw effect sample; 8-bit mode is unsigned, centered and shifted up
    function automatic logic signed [SAMPLE_W-1:0] load_sample(
        input logic [SAMPLE_W-1:0] raw,
        input logic                is8
    );
        return is8 ? {~raw[7], raw[6:0], 8'h00} : raw;
    endfunction

    // prev*F + (next-prev)*u
    function automatic logic signed [NUM_W-1:0] interp_num(
        input logic signed [SAMPLE_W-1:0] prev,
        input logic signed [SAMPLE_W-1:0] next,
        input logic [FACTOR_W-1:0]        f,
        input logic [PHASE_W-1:0]         u
    );
        logic signed [NUM_W-1:0] p;
        logic signed [NUM_W-1:0] d;
        logic signed [NUM_W-1:0] fs;
        logic signed [NUM_W-1:0] us;
        p  = NUM_W'(prev);
        d  = NUM_W'(next) - p;
        fs = NUM_W'({1'b0, f});
        us = NUM_W'({1'b0, u});
        return (p * fs) + (d * us);
    endfunction

    // Restoring division, DIV_RADIX quotient bits per call
    function automatic div_state_t div_step(
        input div_state_t          s,
        input logic [FACTOR_W-1:0] d
    );
        div_state_t         r;
        logic [FACTOR_W:0]  trial;
        r = s;
        for (int i = 0; i < DIV_RADIX; i++)
        begin
            trial = {r.rem, r.quo[DIV_W-1]};
            r.quo = {r.quo[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, d})
            begin
                r.rem    = FACTOR_W'(trial - {1'b0, d});
                r.quo[0] = 1'b1;
            end
            else
            begin
                r.rem = trial[FACTOR_W-1:0];
            end
        end
        return r;
    endfunction

    // Drop the gain fraction, truncating toward zero
    function automatic logic signed [SAMPLE_W-1:0] scale_trunc(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] adj;
        adj = p[PROD_W-1] ? (p + PROD_W'(65535)) : p;
        return SAMPLE_W'(adj >>> GAIN_SHIFT);
    endfunction

    // Add music and effect, clamp to 16 bits
    function automatic sat_t saturate(
        input logic signed [SAMPLE_W-1:0] music,
        input logic signed [SAMPLE_W-1:0] effect
    );
        logic signed [SAMPLE_W:0] sum;
        sat_t r;
        sum = {music[SAMPLE_W-1], music} + {effect[SAMPLE_W-1], effect};
        if (sum[SAMPLE_W:SAMPLE_W-1] == 2'b01)
        begin
            r.sample = 16'sh7FFF;
            r.clip   = CLIP_HIGH;
        end
        else if (sum[SAMPLE_W:SAMPLE_W-1] == 2'b10)
        begin
            r.sample = 16'sh8000;
            r.clip   = CLIP_LOW;
        end
        else
        begin
            r.sample = sum[SAMPLE_W-1:0];
            r.clip   = CLIP_NONE;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/uem_ctrl.sv */
`default_nettype none

module uem_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [uem_pkg::FUNC_W-1:0]  func,
    output logic                             in_ready,
    output uem_pkg::cmd_t                    cmd,
    input  wire uem_pkg::status_t            status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NUM   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [uem_pkg::DIV_CNT_W-1:0] CNT_LAST =
        uem_pkg::DIV_CNT_W'(uem_pkg::DIV_STEPS - 1);

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [uem_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [uem_pkg::DIV_CNT_W-1:0]   cnt_next;

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && (func == uem_pkg::FUNC_MIX))
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                cmd.num_en = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_mix_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && (func == uem_pkg::FUNC_MIX)) |=> (state_reg == ST_NUM))
        else $error("mix item did not start the numerator step");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (cnt_reg == CNT_LAST)) |=> (state_reg == ST_SCALE))
        else $error("divider did not finish after its last step");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ST_IDLE))
        else $error("controller not idle after emitting a result");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.num_en, cmd.div_step, cmd.scale_en, cmd.emit}))
        else $error("more than one datapath command at once");

endmodule

`default_nettype wire

/* design/uem_dp.sv */
`default_nettype none

module uem_dp (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire uem_pkg::cmd_t                          cmd,
    output uem_pkg::status_t                            status,
    input  wire logic                                   cfg_we,
    input  wire logic [uem_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [uem_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic [uem_pkg::FUNC_W-1:0]             func,
    input  wire logic signed [uem_pkg::SAMPLE_W-1:0]    effect_left,
    input  wire logic signed [uem_pkg::SAMPLE_W-1:0]    effect_right,
    input  wire logic signed [uem_pkg::SAMPLE_W-1:0]    music_left,
    input  wire logic signed [uem_pkg::SAMPLE_W-1:0]    music_right,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [uem_pkg::SAMPLE_W-1:0]         mixed_left,
    output logic signed [uem_pkg::SAMPLE_W-1:0]         mixed_right,
    output logic [uem_pkg::CLIP_W-1:0]                  clip_left,
    output logic [uem_pkg::CLIP_W-1:0]                  clip_right
);

    // Configuration
    logic [uem_pkg::FACTOR_W-1:0]          factor_reg;
    logic                                  is8_reg;
    logic                                  stereo_reg;

    // Interpolation history
    logic signed [uem_pkg::SAMPLE_W-1:0]   prev_l_reg;
    logic signed [uem_pkg::SAMPLE_W-1:0]   prev_r_reg;
    logic signed [uem_pkg::SAMPLE_W-1:0]   next_l_reg;
    logic signed [uem_pkg::SAMPLE_W-1:0]   next_r_reg;
    logic [uem_pkg::PHASE_W-1:0]           phase_reg;
    logic [uem_pkg::PHASE_W-1:0]           phase_next;

    // Working registers of one mix
    logic [uem_pkg::PHASE_W-1:0]           u_reg;
    logic signed [uem_pkg::SAMPLE_W-1:0]   music_l_reg;
    logic signed [uem_pkg::SAMPLE_W-1:0]   music_r_reg;
    logic                                  neg_l_reg;
    logic                                  neg_r_reg;
    uem_pkg::div_state_t                   div_l_reg;
    uem_pkg::div_state_t                   div_r_reg;
    logic signed [uem_pkg::PROD_W-1:0]     prod_l_reg;
    logic signed [uem_pkg::PROD_W-1:0]     prod_r_reg;

    // Output register
    logic                                  out_valid_reg;
    logic signed [uem_pkg::SAMPLE_W-1:0]   mixed_l_reg;
    logic signed [uem_pkg::SAMPLE_W-1:0]   mixed_r_reg;
    logic [uem_pkg::CLIP_W-1:0]            clip_l_reg;
    logic [uem_pkg::CLIP_W-1:0]            clip_r_reg;

    logic [uem_pkg::FACTOR_W-1:0]          f_eff;
    logic [uem_pkg::FACTOR_W-1:0]          f_last;
    logic [uem_pkg::PHASE_W-1:0]           u_eff;
    logic signed [uem_pkg::SAMPLE_W-1:0]   load_l;
    logic signed [uem_pkg::SAMPLE_W-1:0]   load_r;
    logic signed [uem_pkg::NUM_W-1:0]      num_l;
    logic signed [uem_pkg::NUM_W-1:0]      num_r;
    logic [uem_pkg::NUM_W-1:0]             mag_l;
    logic [uem_pkg::NUM_W-1:0]             mag_r;
    logic signed [uem_pkg::INTERP_W-1:0]   interp_l;
    logic signed [uem_pkg::INTERP_W-1:0]   interp_r;
    logic signed [uem_pkg::PROD_W-1:0]     interp_l_ext;
    logic signed [uem_pkg::PROD_W-1:0]     interp_r_ext;
    uem_pkg::sat_t                         sat_l;
    uem_pkg::sat_t                         sat_r;
    logic                                  take_load;
    logic                                  take_mix;
    logic                                  take_restart;

    // Factor of zero counts as one; clamp phase to factor-1
    always_comb
    begin
        f_eff      = (factor_reg == '0) ? uem_pkg::FACTOR_W'(1) : factor_reg;
        f_last     = f_eff - 1'b1;
        u_eff      = (phase_reg > f_last) ? f_last : phase_reg;
        phase_next = (u_eff < f_last) ? (u_eff + 1'b1) : u_eff;
    end

    // Decode item function
    assign take_load    = cmd.take && (func == uem_pkg::FUNC_LOAD);
    assign take_mix     = cmd.take && (func == uem_pkg::FUNC_MIX);
    assign take_restart = cmd.take && (func == uem_pkg::FUNC_RESTART);

    // Expand incoming effect frame; mono copies left to right
    assign load_l = uem_pkg::load_sample(effect_left, is8_reg);
    assign load_r = stereo_reg ? uem_pkg::load_sample(effect_right, is8_reg) : load_l;

    // Numerator and its magnitude for the divider
    always_comb
    begin
        num_l = uem_pkg::interp_num(prev_l_reg, next_l_reg, f_eff, u_reg);
        num_r = uem_pkg::interp_num(prev_r_reg, next_r_reg, f_eff, u_reg);
        mag_l = num_l[uem_pkg::NUM_W-1] ? (-num_l) : num_l;
        mag_r = num_r[uem_pkg::NUM_W-1] ? (-num_r) : num_r;
    end

    // Restore sign of quotient
    always_comb
    begin
        interp_l = neg_l_reg ? (-div_l_reg.quo[uem_pkg::INTERP_W-1:0])
                             : div_l_reg.quo[uem_pkg::INTERP_W-1:0];
        interp_r = neg_r_reg ? (-div_r_reg.quo[uem_pkg::INTERP_W-1:0])
                             : div_r_reg.quo[uem_pkg::INTERP_W-1:0];
        interp_l_ext = uem_pkg::PROD_W'(interp_l);
        interp_r_ext = uem_pkg::PROD_W'(interp_r);
    end

    // Drop gain fraction, add music, clamp
    assign sat_l = uem_pkg::saturate(music_l_reg, uem_pkg::scale_trunc(prod_l_reg));
    assign sat_r = uem_pkg::saturate(music_r_reg, uem_pkg::scale_trunc(prod_r_reg));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= uem_pkg::FACTOR_W'(1);
            is8_reg    <= 1'b0;
            stereo_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == uem_pkg::CFG_FACTOR)
            begin
                factor_reg <= cfg_data[uem_pkg::FACTOR_W-1:0];
            end
            if (cfg_index == uem_pkg::CFG_8BIT)
            begin
                is8_reg <= cfg_data[0];
            end
            if (cfg_index == uem_pkg::CFG_STEREO)
            begin
                stereo_reg <= cfg_data[0];
            end
        end
    end

    // Update history on load, restart and mix items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            next_l_reg <= '0;
            next_r_reg <= '0;
            phase_reg  <= '0;
        end
        else if (take_load)
        begin
            prev_l_reg <= next_l_reg;
            prev_r_reg <= next_r_reg;
            next_l_reg <= load_l;
            next_r_reg <= load_r;
            phase_reg  <= '0;
        end
        else if (take_restart)
        begin
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            next_l_reg <= '0;
            next_r_reg <= '0;
            phase_reg  <= '0;
        end
        else if (take_mix)
        begin
            phase_reg <= phase_next;
        end
    end

    // Mix working registers
    always_ff @(posedge clk)
    begin
        if (take_mix)
        begin
            u_reg       <= u_eff;
            music_l_reg <= music_left;
            music_r_reg <= music_right;
        end
        if (cmd.num_en)
        begin
            neg_l_reg     <= num_l[uem_pkg::NUM_W-1];
            neg_r_reg     <= num_r[uem_pkg::NUM_W-1];
            div_l_reg.rem <= '0;
            div_l_reg.quo <= mag_l[uem_pkg::DIV_W-1:0];
            div_r_reg.rem <= '0;
            div_r_reg.quo <= mag_r[uem_pkg::DIV_W-1:0];
        end
        else if (cmd.div_step)
        begin
            div_l_reg <= uem_pkg::div_step(div_l_reg, f_eff);
            div_r_reg <= uem_pkg::div_step(div_r_reg, f_eff);
        end
        if (cmd.scale_en)
        begin
            prod_l_reg <= interp_l_ext * uem_pkg::PROD_W'(uem_pkg::GAIN);
            prod_r_reg <= interp_r_ext * uem_pkg::PROD_W'(uem_pkg::GAIN);
        end
    end

    // Output valid: set on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            mixed_l_reg <= sat_l.sample;
            mixed_r_reg <= sat_r.sample;
            clip_l_reg  <= sat_l.clip;
            clip_r_reg  <= sat_r.clip;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign mixed_left      = mixed_l_reg;
    assign mixed_right     = mixed_r_reg;
    assign clip_left       = clip_l_reg;
    assign clip_right      = clip_r_reg;

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result emitted over one not yet taken");

    a_phase_reset_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (take_load || take_restart) |=> (phase_reg == '0))
        else $error("phase not cleared by load or restart");

    a_clip_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((clip_l_reg != uem_pkg::CLIP_HIGH) ||
                           (mixed_l_reg == 16'sh7FFF)))
        else $error("high clip flag without a clamped sample");

endmodule

`default_nettype wire

/* design/upsampling_effect_mixer.sv */
`default_nettype none

// Channel   Handshake                Payload
// input     in_valid / in_ready      func, effect_left/right, music_left/right
// output    out_valid / out_ready    mixed_left/right, clip_left/right
// config    cfg_we (no wait)         cfg_index, cfg_data
//
// Load and restart items complete when they are accepted. A mix item goes from
// acceptance to its result in the output register through the numerator
// step, the steps of the radix-16 divider by the upsample factor, the gain
// multiply and clamping; the next item is accepted once that result is
// emitted. One item is in work at a time.
// Reset is asynchronous, active low, and restores the register defaults
// and a cleared interpolation history. A result waiting at the output
// does not block the next item; a mix stalls only in its emit step.

module upsampling_effect_mixer (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [uem_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [uem_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [uem_pkg::FUNC_W-1:0]             func,
    input  wire logic signed [uem_pkg::SAMPLE_W-1:0]    effect_left,
    input  wire logic signed [uem_pkg::SAMPLE_W-1:0]    effect_right,
    input  wire logic signed [uem_pkg::SAMPLE_W-1:0]    music_left,
    input  wire logic signed [uem_pkg::SAMPLE_W-1:0]    music_right,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [uem_pkg::SAMPLE_W-1:0]         mixed_left,
    output logic signed [uem_pkg::SAMPLE_W-1:0]         mixed_right,
    output logic [uem_pkg::CLIP_W-1:0]                  clip_left,
    output logic [uem_pkg::CLIP_W-1:0]                  clip_right
);

    uem_pkg::cmd_t    cmd;
    uem_pkg::status_t status;

    uem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    uem_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .effect_left  (effect_left),
        .effect_right (effect_right),
        .music_left   (music_left),
        .music_right  (music_right),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_left   (mixed_left),
        .mixed_right  (mixed_right),
        .clip_left    (clip_left),
        .clip_right   (clip_right)
    );

endmodule

`default_nettype wire

/* bench/upsampling_effect_mixer_tb.sv */
`timescale 1ns / 100ps

module upsampling_effect_mixer_tb;

    import uem_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int GAP_PCT      = 35;
    localparam int NUM_SETTINGS = 8;
    localparam int PHASE_ITEMS  = 235;
    localparam int GAIN_NUM     = 19661;
    localparam int GAIN_DIV     = 65536;
    localparam int SAT_HIGH     = 32767;
    localparam int SAT_LOW      = -32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_l;
        logic signed [SAMPLE_W-1:0] mixed_r;
        logic [CLIP_W-1:0]          clip_l;
        logic [CLIP_W-1:0]          clip_r;
    } mix_frame_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [FUNC_W-1:0]            func;
    logic signed [SAMPLE_W-1:0]   effect_left;
    logic signed [SAMPLE_W-1:0]   effect_right;
    logic signed [SAMPLE_W-1:0]   music_left;
    logic signed [SAMPLE_W-1:0]   music_right;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [SAMPLE_W-1:0]   mixed_left;
    logic signed [SAMPLE_W-1:0]   mixed_right;
    logic [CLIP_W-1:0]            clip_left;
    logic [CLIP_W-1:0]            clip_right;

    // Shadow of the block's registers and interpolation history
    logic [FACTOR_W-1:0]          cur_factor;
    logic                         cur_is8;
    logic                         cur_stereo;
    int                           hist_prev_l;
    int                           hist_prev_r;
    int                           hist_next_l;
    int                           hist_next_r;
    logic [PHASE_W-1:0]           cur_phase;

    mix_frame_t                   expected_mixes[$];
    mix_frame_t                   want_frame;
    mix_frame_t                   got_frame;
    bit                           steady_flow = 1'b0;

    int mismatches = 0;
    int n_checked  = 0;
    int n_mixes    = 0;
    int n_loads    = 0;
    int n_restarts = 0;
    int n_ignored  = 0;
    int n_settings = 0;

    upsampling_effect_mixer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .effect_left  (effect_left),
        .effect_right (effect_right),
        .music_left   (music_left),
        .music_right  (music_right),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_left   (mixed_left),
        .mixed_right  (mixed_right),
        .clip_left    (clip_left),
        .clip_right   (clip_right)
    );

    always #5 clk = ~clk;

    // Stall the result side at random unless flow is steady
    always @(posedge clk)
    begin
        out_ready <= steady_flow || ($urandom_range(99) >= GAP_PCT);
    end

    // Turn a raw effect sample into a 16-bit signed value
    function automatic int expand_effect(input logic [SAMPLE_W-1:0] raw);
        if (cur_is8)
            return (int'(raw[7:0]) - 128) * 256;
        return int'($signed(raw));
    endfunction

    // Interpolate one channel, apply the gain, add music and clamp
    function automatic void blend_channel(
        input  int                         prev_s,
        input  int                         next_s,
        input  logic signed [SAMPLE_W-1:0] music,
        input  int                         f,
        input  int                         u,
        output logic signed [SAMPLE_W-1:0] sample,
        output logic [CLIP_W-1:0]          clip
    );
        int num;
        int interp;
        int scaled;
        int sum;
        num    = prev_s * f + (next_s - prev_s) * u;
        interp = num / f;
        scaled = (interp * GAIN_NUM) / GAIN_DIV;
        sum    = int'(music) + scaled;
        clip   = CLIP_NONE;
        if (sum > SAT_HIGH)
        begin
            sum  = SAT_HIGH;
            clip = CLIP_HIGH;
        end
        else if (sum < SAT_LOW)
        begin
            sum  = SAT_LOW;
            clip = CLIP_LOW;
        end
        sample = SAMPLE_W'(sum);
    endfunction

    // Advance the shadow state by one accepted item and queue any mix result
    task automatic predict_item(
        input logic [FUNC_W-1:0]   fn,
        input logic [SAMPLE_W-1:0] el,
        input logic [SAMPLE_W-1:0] er,
        input logic [SAMPLE_W-1:0] ml,
        input logic [SAMPLE_W-1:0] mr
    );
        int         f;
        int         u;
        int         l;
        int         r;
        mix_frame_t fr;
        case (fn)
            FUNC_LOAD:
            begin
                l = expand_effect(el);
                r = cur_stereo ? expand_effect(er) : l;
                hist_prev_l = hist_next_l;
                hist_prev_r = hist_next_r;
                hist_next_l = l;
                hist_next_r = r;
                cur_phase   = '0;
                n_loads++;
            end
            FUNC_RESTART:
            begin
                hist_prev_l = 0;
                hist_prev_r = 0;
                hist_next_l = 0;
                hist_next_r = 0;
                cur_phase   = '0;
                n_restarts++;
            end
            FUNC_MIX:
            begin
                f = (cur_factor == 0) ? 1 : int'(cur_factor);
                u = int'(cur_phase);
                if (u > f - 1)
                    u = f - 1;
                blend_channel(hist_prev_l, hist_next_l, ml, f, u, fr.mixed_l, fr.clip_l);
                blend_channel(hist_prev_r, hist_next_r, mr, f, u, fr.mixed_r, fr.clip_r);
                expected_mixes.push_back(fr);
                if (u < f - 1)
                    u++;
                cur_phase = PHASE_W'(u);
                n_mixes++;
            end
            default:
            begin
                n_ignored++;
            end
        endcase
    endtask

    // Offer one item, idling at random first, and predict it once accepted
    task automatic send_item(
        input logic [FUNC_W-1:0]   fn,
        input logic [SAMPLE_W-1:0] el,
        input logic [SAMPLE_W-1:0] er,
        input logic [SAMPLE_W-1:0] ml,
        input logic [SAMPLE_W-1:0] mr
    );
        while (!steady_flow && $urandom_range(99) < GAP_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= fn;
        effect_left  <= el;
        effect_right <= er;
        music_left   <= ml;
        music_right  <= mr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(fn, el, er, ml, mr);
    endtask

    // Drop valid, drain every expected result, then let trailing work settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_mixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write all three registers while the block is idle
    task automatic set_config(input logic [FACTOR_W-1:0] f, input logic is8,
                              input logic st);
        wait_idle();
        write_reg(CFG_FACTOR, CFG_DATA_W'(f));
        write_reg(CFG_8BIT, CFG_DATA_W'(is8));
        write_reg(CFG_STEREO, CFG_DATA_W'(st));
        cfg_we     <= 1'b0;
        cur_factor  = f;
        cur_is8     = is8;
        cur_stereo  = st;
        n_settings++;
    endtask

    // Favor full-scale values so clipping shows up often
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Full-scale effect and music at reset settings, clip both ways
    task automatic test_extremes();
        send_item(FUNC_LOAD, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        send_item(FUNC_MIX, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
        send_item(FUNC_LOAD, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
        send_item(FUNC_MIX, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
    endtask

    // Walk every phase of a factor of four and hold at the last one
    task automatic test_interpolation();
        set_config(6'd4, 1'b0, 1'b1);
        send_item(FUNC_LOAD, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
        send_item(FUNC_LOAD, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        repeat (5) send_item(FUNC_MIX, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
    endtask

    // Unsigned 8-bit mono effect: low byte only, left copied to right
    task automatic test_8bit_mono();
        set_config(6'd4, 1'b1, 1'b0);
        send_item(FUNC_LOAD, 16'hFF00, 16'h1234, 16'h0000, 16'h0000);
        send_item(FUNC_LOAD, 16'h00FF, 16'hABCD, 16'h0000, 16'h0000);
        send_item(FUNC_MIX, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
    endtask

    // Lower the factor below the phase, then use a factor of zero
    task automatic test_phase_clamp();
        set_config(6'd8, 1'b0, 1'b1);
        send_item(FUNC_LOAD, 16'(1000), 16'(-1000), 16'h0000, 16'h0000);
        send_item(FUNC_LOAD, 16'(-20000), 16'(20000), 16'h0000, 16'h0000);
        repeat (4) send_item(FUNC_MIX, 16'h0000, 16'h0000, pick_sample(), pick_sample());
        set_config(6'd3, 1'b0, 1'b1);
        send_item(FUNC_MIX, 16'h0000, 16'h0000, 16'h0123, 16'hFEDC);
        set_config(6'd0, 1'b0, 1'b1);
        send_item(FUNC_MIX, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Unused code must leave history alone; restart must clear it
    task automatic test_restart_and_unused();
        send_item(FUNC_UNUSED, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_item(FUNC_MIX, 16'h0000, 16'h0000, 16'h1000, 16'hF000);
        send_item(FUNC_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_MIX, 16'h0000, 16'h0000, 16'h1000, 16'hF000);
    endtask

    // Load-then-mix bursts, restarts, unused codes and lone mixes with random content over several settings
    task automatic test_random_streams();
        logic [FACTOR_W-1:0] factors [NUM_SETTINGS] = '{1, 44, 2, 7, 16, 3, 29, 5};
        logic [FACTOR_W-1:0] f;
        int                  sent;
        int                  burst;
        int                  pick;
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            f = (p == NUM_SETTINGS - 1) ? FACTOR_W'($urandom_range(1, 44)) : factors[p];
            set_config(f, 1'(p & 1), 1'((p >> 1) & 1));
            steady_flow = (p == 4);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 84)
                begin
                    send_item(FUNC_LOAD, pick_sample(), pick_sample(),
                              SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                    sent++;
                    burst = $urandom_range(1, int'(cur_factor) + 2);
                    repeat (burst)
                    begin
                        send_item(FUNC_MIX, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                                  pick_sample(), pick_sample());
                        sent++;
                    end
                end
                else if (pick < 90)
                begin
                    send_item(FUNC_RESTART, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                              SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                    sent++;
                end
                else if (pick < 94)
                begin
                    send_item(FUNC_UNUSED, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                              SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                end
                else
                begin
                    send_item(FUNC_MIX, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                              pick_sample(), pick_sample());
                    sent++;
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    // Compare each accepted result with the oldest expected mix
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_frame = '{mixed_left, mixed_right, clip_left, clip_right};
            if (expected_mixes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result L=%0d R=%0d clip %0d/%0d at %0t",
                             got_frame.mixed_l, got_frame.mixed_r,
                             got_frame.clip_l, got_frame.clip_r, $realtime);
            end
            else
            begin
                want_frame = expected_mixes.pop_front();
                n_checked++;
                if (got_frame !== want_frame)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: expected L=%0d R=%0d clip %0d/%0d, got L=%0d R=%0d clip %0d/%0d",
                                 $realtime, want_frame.mixed_l, want_frame.mixed_r,
                                 want_frame.clip_l, want_frame.clip_r,
                                 got_frame.mixed_l, got_frame.mixed_r,
                                 got_frame.clip_l, got_frame.clip_r);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_FACTOR;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        func         <= FUNC_LOAD;
        effect_left  <= '0;
        effect_right <= '0;
        music_left   <= '0;
        music_right  <= '0;
        out_ready    <= 1'b0;
        cur_factor    = 6'd1;
        cur_is8       = 1'b0;
        cur_stereo    = 1'b1;
        hist_prev_l   = 0;
        hist_prev_r   = 0;
        hist_next_l   = 0;
        hist_next_r   = 0;
        cur_phase     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_interpolation();
        test_8bit_mono();
        test_phase_clamp();
        test_restart_and_unused();
        test_random_streams();
        wait_idle();

        $display("covered %0d mixes (%0d checked), %0d loads, %0d restarts, %0d ignored items",
                 n_mixes, n_checked, n_loads, n_restarts, n_ignored);
        $display("over %0d register settings, %0d mismatches", n_settings, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
